@@ sv/lcg48_pkg.sv @@
package lcg48_pkg;

  // Widths of the generator state and of the item fields.
  localparam int StateW  = 48;
  localparam int ModeW   = 2;
  localparam int LowW    = 32;
  localparam int SpanW   = 31;
  localparam int RangedW = 33;

  // Default digit width of the shared multiplier (bits of operand b per cycle).
  localparam int MulChunkW = 16;

  // Generator constants: multiplier 5^19, increment 1, stream stride.
  localparam logic [StateW-1:0] LcgMult    = 48'd19073486328125;
  localparam logic [StateW-1:0] LcgInc     = 48'd1;
  localparam logic [StateW-1:0] SeedStride = 48'd152917;
  localparam logic [StateW-1:0] ResetSeed  = 48'd1;
  localparam logic [StateW-1:0] ResetState = 48'd1;

  // Item modes.
  localparam logic [ModeW-1:0] ModeNext = 2'd0;
  localparam logic [ModeW-1:0] ModeSkip = 2'd1;
  localparam logic [ModeW-1:0] ModeSeed = 2'd2;

  // Request to the shared multiply-accumulate unit: a * b + addend.
  typedef struct packed {
    logic              start;
    logic [StateW-1:0] a;
    logic [StateW-1:0] b;
    logic [StateW-1:0] addend;
  } mac_req_t;

endpackage

@@ sv/lcg48_mac.sv @@
// Multi-cycle multiply-accumulate: computes a * b + addend at full precision,
// taking ChunkW bits of b per cycle, least significant digit first.
module lcg48_mac #(
  parameter int ChunkW = lcg48_pkg::MulChunkW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lcg48_pkg::mac_req_t         req_i,
  output logic                        done_o,
  output logic [lcg48_pkg::StateW-1:0] lo_o,
  output logic [lcg48_pkg::SpanW-1:0]  hi_o
);

  localparam int W     = lcg48_pkg::StateW;
  localparam int Steps = (W + ChunkW - 1) / ChunkW;
  localparam int BPadW = Steps * ChunkW;
  localparam int SumW  = W + ChunkW + 1;
  localparam int HiW   = SumW - ChunkW;
  localparam int PW    = HiW + BPadW;
  localparam int CntW  = (Steps > 1) ? $clog2(Steps) : 1;

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [W-1:0]     a_q;
  logic [BPadW-1:0] b_q;
  logic [HiW-1:0]   hi_q;
  logic [BPadW-1:0] lo_q;

  logic [W+ChunkW-1:0] pp;
  logic [SumW-1:0]     sum;
  logic [PW-1:0]       prod;

  // One partial product per cycle, added to the running upper part.
  assign pp   = {{ChunkW{1'b0}}, a_q} * {{W{1'b0}}, b_q[ChunkW-1:0]};
  assign sum  = {1'b0, pp} + {{(SumW-HiW){1'b0}}, hi_q};
  assign prod = {hi_q, lo_q};

  // Sequencing of the digit steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and product registers; the addend seeds the accumulation.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q  <= req_i.a;
      b_q  <= BPadW'(req_i.b);
      hi_q <= HiW'(req_i.addend);
    end else if (busy_q) begin
      b_q  <= b_q >> ChunkW;
      hi_q <= sum[SumW-1:ChunkW];
      lo_q <= {sum[ChunkW-1:0], lo_q[BPadW-1:ChunkW]};
    end
  end

  assign done_o = done_q;
  assign lo_o   = prod[W-1:0];
  assign hi_o   = prod[W +: lcg48_pkg::SpanW];

endmodule

@@ sv/lcg48_skip_ahead_generator_unit.sv @@
// A next word's result runs through the step multiply and the scale multiply, then waits in
// the emit state for the output register. A skip word replaces the step multiply with
// a check state and two or four multiplies per count bit up to the highest set one, then one
// more check state and the final multiply; a seed word first adds the stride multiply.
// The block takes one word at a time; the input
// reopens as the result loads, even while it waits in the output register. Reset sets both.
module lcg48_skip_ahead_generator_unit #(
  parameter int ChunkW = lcg48_pkg::MulChunkW
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lcg48_pkg::StateW-1:0]        cfg_master_seed_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lcg48_pkg::ModeW-1:0]         mode_i,
  input  logic [lcg48_pkg::StateW-1:0]        skip_count_i,
  input  logic [lcg48_pkg::StateW-1:0]        stream_id_i,
  input  logic signed [lcg48_pkg::LowW-1:0]   low_bound_i,
  input  logic [lcg48_pkg::SpanW-1:0]         span_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lcg48_pkg::StateW-1:0]        state_value_o,
  output logic signed [lcg48_pkg::RangedW-1:0] ranged_value_o
);

  localparam int W = lcg48_pkg::StateW;

  typedef enum logic [10:0] {
    StIdle    = 11'b000_0000_0001,
    StSeedMul = 11'b000_0000_0010,
    StJmpChk  = 11'b000_0000_0100,
    StAccG    = 11'b000_0000_1000,
    StAccC    = 11'b000_0001_0000,
    StStepC   = 11'b000_0010_0000,
    StStepG   = 11'b000_0100_0000,
    StFinal   = 11'b000_1000_0000,
    StNext    = 11'b001_0000_0000,
    StScale   = 11'b010_0000_0000,
    StEmit    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   issued_q, issued_d;
  logic   out_valid_q, out_valid_d;
  logic   load_out;

  logic [W-1:0] seed_q, st_q, st_d;
  logic [W-1:0] n_q, n_d, g_q, g_d, c_q, c_d, accg_q, accg_d, accc_q, accc_d;
  logic [W-1:0] base_q, base_d;
  logic [lcg48_pkg::LowW-1:0]    low_q, low_d;
  logic [lcg48_pkg::SpanW-1:0]   span_q, span_d;
  logic [W-1:0]                  state_out_q;
  logic [lcg48_pkg::RangedW-1:0] ranged_q, ranged_sum;

  lcg48_pkg::mac_req_t        mac_req;
  logic                       mac_done;
  logic [W-1:0]               mac_lo;
  logic [lcg48_pkg::SpanW-1:0] mac_hi;
  logic                       mul_state;

  lcg48_mac #(.ChunkW(ChunkW)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .done_o (mac_done),
    .lo_o   (mac_lo),
    .hi_o   (mac_hi)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mac_req.a      = '0;
    mac_req.b      = '0;
    mac_req.addend = '0;
    mul_state      = 1'b1;
    case (state_q)
      StSeedMul: begin
        mac_req.a = n_q;
        mac_req.b = lcg48_pkg::SeedStride;
      end
      StAccG: begin
        mac_req.a = accg_q;
        mac_req.b = g_q;
      end
      StAccC: begin
        mac_req.a      = accc_q;
        mac_req.b      = g_q;
        mac_req.addend = c_q;
      end
      StStepC: begin
        mac_req.a      = c_q;
        mac_req.b      = g_q;
        mac_req.addend = c_q;
      end
      StStepG: begin
        mac_req.a = g_q;
        mac_req.b = g_q;
      end
      StFinal: begin
        mac_req.a      = accg_q;
        mac_req.b      = base_q;
        mac_req.addend = accc_q;
      end
      StNext: begin
        mac_req.a      = st_q;
        mac_req.b      = lcg48_pkg::LcgMult;
        mac_req.addend = lcg48_pkg::LcgInc;
      end
      StScale: begin
        mac_req.a = W'(span_q);
        mac_req.b = st_q;
      end
      default: mul_state = 1'b0;
    endcase
    mac_req.start = mul_state && !issued_q;
  end

  // Ranged result: sign-extended low bound plus the scaled state.
  assign ranged_sum = {low_q[lcg48_pkg::LowW-1], low_q} + {2'b00, mac_hi};

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    st_d        = st_q;
    n_d         = n_q;
    g_d         = g_q;
    c_d         = c_q;
    accg_d      = accg_q;
    accc_d      = accc_q;
    base_d      = base_q;
    low_d       = low_q;
    span_d      = span_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    if (mul_state && !issued_q) begin
      issued_d = 1'b1;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          low_d  = low_bound_i;
          span_d = span_i;
          g_d    = lcg48_pkg::LcgMult;
          c_d    = lcg48_pkg::LcgInc;
          accg_d = W'(1);
          accc_d = '0;
          case (mode_i)
            lcg48_pkg::ModeNext: begin
              state_d = StNext;
            end
            lcg48_pkg::ModeSkip: begin
              n_d     = skip_count_i;
              base_d  = st_q;
              state_d = StJmpChk;
            end
            lcg48_pkg::ModeSeed: begin
              n_d     = stream_id_i;
              base_d  = seed_q;
              state_d = StSeedMul;
            end
            default: state_d = StScale;
          endcase
        end
      end
      StSeedMul: begin
        if (mac_done) begin
          n_d      = mac_lo;
          issued_d = 1'b0;
          state_d  = StJmpChk;
        end
      end
      StJmpChk: begin
        if (n_q == '0) begin
          state_d = StFinal;
        end else if (n_q[0]) begin
          state_d = StAccG;
        end else begin
          state_d = StStepC;
        end
      end
      StAccG: begin
        if (mac_done) begin
          accg_d   = mac_lo;
          issued_d = 1'b0;
          state_d  = StAccC;
        end
      end
      StAccC: begin
        if (mac_done) begin
          accc_d   = mac_lo;
          issued_d = 1'b0;
          state_d  = StStepC;
        end
      end
      StStepC: begin
        if (mac_done) begin
          c_d      = mac_lo;
          issued_d = 1'b0;
          state_d  = StStepG;
        end
      end
      StStepG: begin
        if (mac_done) begin
          g_d      = mac_lo;
          n_d      = n_q >> 1;
          issued_d = 1'b0;
          state_d  = StJmpChk;
        end
      end
      StFinal, StNext: begin
        if (mac_done) begin
          st_d     = mac_lo;
          issued_d = 1'b0;
          state_d  = StScale;
        end
      end
      StScale: begin
        if (mac_done) begin
          issued_d = 1'b0;
          state_d  = StEmit;
        end
      end
      StEmit: begin
        // The multiplier holds the scaled value until the output slot frees up.
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= lcg48_pkg::ResetState;
      seed_q      <= lcg48_pkg::ResetSeed;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
      if (cfg_valid_i) begin
        seed_q <= cfg_master_seed_i;
      end
    end
  end

  // Working registers of the jump and the output word.
  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    g_q    <= g_d;
    c_q    <= c_d;
    accg_q <= accg_d;
    accc_q <= accc_d;
    base_q <= base_d;
    low_q  <= low_d;
    span_q <= span_d;
    if (load_out) begin
      state_out_q <= st_q;
      ranged_q    <= ranged_sum;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = out_valid_q;
  assign state_value_o  = state_out_q;
  assign ranged_value_o = ranged_q;

endmodule

@@ sv/lcg48_checker.sv @@
module lcg48_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [lcg48_pkg::StateW-1:0]        state_value_o,
  input logic signed [lcg48_pkg::RangedW-1:0] ranged_value_o
);

  logic [1:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Words accepted whose results have not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(state_value_o)
      && $stable(ranged_value_o))
    else $error("result word changed while stalled");

  // An accepted word keeps the input closed for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input ready right after accepting a word");

  // No result appears without an accepted word behind it.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("result word without a pending input");

  // At most one word in work and one waiting at the output.
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many words in flight");

  // The seed register is always writable.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind lcg48_skip_ahead_generator_unit lcg48_checker u_lcg48_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_o    (cfg_ready_o),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .state_value_o  (state_value_o),
  .ranged_value_o (ranged_value_o)
);

@@ tb/sv/lcg48_skip_ahead_generator_unit_test.sv @@
`timescale 1ns / 1ps

module lcg48_skip_ahead_generator_unit_test;
  import lcg48_pkg::*;

  // Mode code that the block leaves unused: the state is held.
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned StallLimit = 20000;
  // Quiet cycles after the last result, to catch stray results.
  localparam int unsigned DrainCycles = 1200;

  localparam logic [LowW-1:0] LowMin = 32'h8000_0000;
  localparam logic [LowW-1:0] LowMax = 32'h7FFF_FFFF;
  localparam logic [SpanW-1:0] SpanMax = '1;

  // One input word of the generator.
  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [StateW-1:0] skip_count;
    logic [StateW-1:0] stream_id;
    logic [LowW-1:0]   low_bound;
    logic [SpanW-1:0]  span;
  } lcg_word_t;

  // One draw reported by the generator.
  typedef struct packed {
    logic [StateW-1:0]  state_value;
    logic [RangedW-1:0] ranged_value;
  } lcg_draw_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              cfg_valid = 1'b0;
  logic [StateW-1:0] cfg_seed = '0;
  logic              in_valid = 1'b0;
  lcg_word_t         in_word = '0;
  logic              out_ready = 1'b0;

  logic                      cfg_ready_o;
  logic                      in_ready_o;
  logic                      out_valid_o;
  logic [StateW-1:0]         state_value_o;
  logic signed [RangedW-1:0] ranged_value_o;

  lcg_word_t pending_words[$];
  lcg_draw_t expected_draws[$];

  // Shadow copy of the generator state and the master seed.
  logic [StateW-1:0] gen_state = ResetState;
  logic [StateW-1:0] gen_master_seed = ResetSeed;

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  lcg48_skip_ahead_generator_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_master_seed_i(cfg_seed),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .mode_i           (in_word.mode),
    .skip_count_i     (in_word.skip_count),
    .stream_id_i      (in_word.stream_id),
    .low_bound_i      (in_word.low_bound),
    .span_i           (in_word.span),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .state_value_o    (state_value_o),
    .ranged_value_o   (ranged_value_o)
  );

  // Free-running 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // State reached from a start value after a number of steps, modulo 2^48.
  function automatic logic [StateW-1:0] jump_state(input logic [StateW-1:0] steps,
                                                   input logic [StateW-1:0] start_value);
    logic [StateW-1:0] mult;
    logic [StateW-1:0] incr;
    logic [StateW-1:0] acc_mult;
    logic [StateW-1:0] acc_incr;
    logic [StateW-1:0] left;
    mult = LcgMult;
    incr = LcgInc;
    acc_mult = 48'd1;
    acc_incr = '0;
    left = steps;
    while (left != '0) begin
      if (left[0]) begin
        acc_mult = acc_mult * mult;
        acc_incr = acc_incr * mult + incr;
      end
      incr = incr * (mult + 48'd1);
      mult = mult * mult;
      left = left >> 1;
    end
    return acc_mult * start_value + acc_incr;
  endfunction

  // Advance the shadow state by one word and build the draw it yields.
  function automatic lcg_draw_t advance_generator(input lcg_word_t word);
    lcg_draw_t draw;
    logic [78:0] product;
    logic [SpanW-1:0] scaled;
    case (word.mode)
      ModeNext: gen_state = LcgMult * gen_state + LcgInc;
      ModeSkip: gen_state = jump_state(word.skip_count, gen_state);
      ModeSeed: gen_state = jump_state(word.stream_id * SeedStride, gen_master_seed);
      default: begin
        // The unused mode keeps the state as it is.
      end
    endcase
    // The ranged value uses the full-width product, never a wrapped one.
    product = 79'(word.span) * 79'(gen_state);
    scaled = product[78:48];
    draw.state_value = gen_state;
    draw.ranged_value = {word.low_bound[LowW-1], word.low_bound} + {2'b00, scaled};
    return draw;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [StateW-1:0] rand48();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[StateW-1:0];
  endfunction

  task automatic add_word(input logic [ModeW-1:0] mode, input logic [StateW-1:0] skip_count,
                          input logic [StateW-1:0] stream_id, input logic [LowW-1:0] low_bound,
                          input logic [SpanW-1:0] span);
    lcg_word_t word;
    word.mode = mode;
    word.skip_count = skip_count;
    word.stream_id = stream_id;
    word.low_bound = low_bound;
    word.span = span;
    pending_words.push_back(word);
  endtask

  // Mostly plain steps; skip counts are spread over every bit length.
  task automatic add_random_words(input int unsigned count);
    lcg_word_t word;
    int unsigned pick;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        word.mode = ModeNext;
      end else if (pick < 75) begin
        word.mode = ModeSkip;
      end else if (pick < 95) begin
        word.mode = ModeSeed;
      end else begin
        word.mode = ModeUnused;
      end
      word.skip_count = rand48() >> $urandom_range(48);
      word.stream_id = $urandom_range(1) ? rand48() : StateW'($urandom_range(2000));
      case ($urandom_range(9))
        0: word.low_bound = LowMin;
        1: word.low_bound = LowMax;
        2: word.low_bound = '0;
        3: word.low_bound = LowW'($signed(-$urandom_range(100)));
        default: word.low_bound = $urandom();
      endcase
      case ($urandom_range(7))
        0: word.span = '0;
        1: word.span = SpanMax;
        2: word.span = SpanW'($urandom_range(1000));
        default: word.span = SpanW'($urandom());
      endcase
      pending_words.push_back(word);
    end
  endtask

  // Wait at a falling edge until every word is taken and every draw is back.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (pending_words.size() != 0 || in_valid || expected_draws.size() != 0);
  endtask

  task automatic write_master_seed(input logic [StateW-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_seed <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    gen_master_seed = value;
  endtask

  // Input driver: a word is offered from the queue unless a gap is drawn.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        expected_draws.push_back(advance_generator(in_word));
      end
      if (!in_valid || in_ready_o) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each draw against the oldest expectation.
  always @(posedge clk_i) begin
    lcg_draw_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (expected_draws.size() == 0) begin
          report_mismatch($sformatf("draw with nothing expected, state %h", state_value_o));
        end else begin
          want = expected_draws.pop_front();
          if (state_value_o !== want.state_value) begin
            report_mismatch($sformatf("state_value got %h want %h",
                                      state_value_o, want.state_value));
          end
          if (ranged_value_o !== want.ranged_value) begin
            report_mismatch($sformatf("ranged_value got %h want %h (state %h)",
                                      ranged_value_o, want.ranged_value, want.state_value));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("[%0t] no handshake for %0d cycles", $time, StallLimit);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sender rarely idles while the receiver stalls most of the time.
    send_gap_pct = 10;
    recv_stall_pct = 76;

    // Directed words with the master seed still at its reset value.
    add_word(ModeNext, '0, '0, '0, '0);
    add_word(ModeNext, '1, '1, LowMin, SpanMax);
    add_word(ModeNext, '0, '0, LowMax, SpanMax);
    add_word(ModeSkip, '0, '1, 32'd5, 31'd1000);
    add_word(ModeSkip, 48'd1, '0, LowMin, '0);
    add_word(ModeSkip, '1, '0, '1, SpanMax);
    add_word(ModeSkip, 48'h8000_0000_0000, '0, LowMax, 31'd1);
    add_word(ModeSkip, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, LowMax, '0);
    add_word(ModeSeed, '1, '0, '0, SpanMax);
    add_word(ModeSeed, '0, 48'd1, LowMin, SpanMax);
    add_word(ModeSeed, '0, '1, 32'h1234_5678, 31'h2AAA_AAAA);
    add_word(ModeSeed, '0, 48'hAAAA_AAAA_AAAA, LowMax, SpanMax);
    add_word(ModeUnused, '1, '1, LowMin, '0);
    add_word(ModeUnused, '0, '0, LowMax, SpanMax);
    add_word(ModeNext, '0, '0, '1, 31'd1);
    add_word(ModeNext, 48'h5555_5555_5555, 48'h5555_5555_5555, 32'h5555_5555, 31'h5555_5555);
    wait_idle();

    write_master_seed('1);
    add_word(ModeSeed, '0, '0, '0, SpanMax);
    add_word(ModeSeed, '0, 48'd3, LowMin, SpanMax);
    add_random_words(275);
    wait_idle();

    // Now the sender idles often and the receiver rarely stalls.
    send_gap_pct = 76;
    recv_stall_pct = 10;
    write_master_seed('0);
    add_word(ModeSeed, '0, '0, LowMax, SpanMax);
    add_random_words(278);
    wait_idle();

    // Full rate on both sides.
    send_gap_pct = 0;
    recv_stall_pct = 0;
    write_master_seed(rand48());
    add_random_words(280);
    wait_idle();

    repeat (DrainCycles) @(posedge clk_i);
    if (expected_draws.size() != 0) begin
      report_mismatch($sformatf("%0d draws never arrived", expected_draws.size()));
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
